// File: sv/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types of the wildcard byte pattern search unit.
// ----------------------------------------------------------------------------
package wbps_pkg;

   // Window depth (number of cells) and width of the region byte counter
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;

   // Pattern bytes held by the configuration registers
   localparam int REG_PATTERN_BYTES = 16;
   localparam int PAT_INDEX_BITS    = $clog2(REG_PATTERN_BYTES);

   // Field widths
   localparam int BYTE_BITS         = 8;
   localparam int LEN_BITS          = 5;
   localparam int MATCH_OFFSET_BITS = 32;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 64;

   // Cell numbering and the width used to compare a cell number with a length
   localparam int CELL_INDEX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam int IDX_CMP_BITS    = (CELL_INDEX_BITS > LEN_BITS) ? CELL_INDEX_BITS : LEN_BITS;

   // Longest pattern in effect
   localparam int LEN_CAP = (MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
                            MAX_PATTERN_BYTES : REG_PATTERN_BYTES;

   // Byte that matches any data byte
   localparam logic [BYTE_BITS-1:0] WILDCARD_BYTE = 8'h2A;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;

   typedef logic [BYTE_BITS-1:0] byte_type;
   typedef logic [REG_PATTERN_BYTES-1:0][BYTE_BITS-1:0] pattern_type;

   // Per-beat control broadcast to every cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

// File: sv/wbps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cell
// One window position: holds one byte, passes it on to its neighbor on each
// shift and checks the byte it takes in against its pattern byte.
// ----------------------------------------------------------------------------
module wbps_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  wbps_pkg::cell_ctrl_type           ctrl,
   input  logic [wbps_pkg::CELL_INDEX_BITS-1:0] cell_index,
   input  logic [wbps_pkg::LEN_BITS-1:0]     eff_len,
   input  wbps_pkg::pattern_type             pattern,
   input  wbps_pkg::byte_type                byte_in,
   output wbps_pkg::byte_type                byte_out,
   output logic                              hit
);
   import wbps_pkg::*;

   byte_type                  byte_ff;
   byte_type                  byte_in_sel;
   logic [IDX_CMP_BITS-1:0]   len_ext;
   logic [IDX_CMP_BITS-1:0]   idx_ext;
   logic [IDX_CMP_BITS-1:0]   pat_pos;
   byte_type                  pat_byte;
   logic                      in_use;

   // Hold, load the neighbor's byte, or drop it at region end
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         byte_ff <= '0;
      end else if (ctrl.shift) begin
         byte_ff <= byte_in;
      end
   end

   // Window entry j pairs with pattern byte (len - 1 - j)
   always_comb begin
      len_ext     = IDX_CMP_BITS'(eff_len);
      idx_ext     = IDX_CMP_BITS'(cell_index);
      in_use      = idx_ext < len_ext;
      pat_pos     = len_ext - idx_ext - IDX_CMP_BITS'(1);
      pat_byte    = pattern[pat_pos[PAT_INDEX_BITS-1:0]];
      byte_in_sel = byte_in;
      hit         = !in_use || (pat_byte == WILDCARD_BYTE) || (pat_byte == byte_in_sel);
   end

   assign byte_out = byte_ff;

endmodule

// File: sv/wildcard_byte_pattern_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_unit
// Finds the first start position in a byte region where a configured
// pattern with 0x2A wildcards matches.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one region byte per beat; req_last_byte marks the region end.
//   rsp_*  : at most one result per region. rsp_found = 1 with the start
//            offset the moment the window matches; rsp_found = 0 with offset
//            0 on the last byte of a region without a match. Bytes after a
//            match give no result.
//   csr_*  : write pattern_low_bytes (0), pattern_high_bytes (1) and
//            pattern_length (2) while the block is idle.
//   Throughput is one byte per cycle while req_ready stays high: the row of
//   window cells shifts and compares in the cycle a byte is taken, so the
//   result register is loaded at that edge and shows the result in the next cycle.
//   The result register sits between the channels: a byte is taken while a
//   result waits, as long as that result is taken in the same cycle; a
//   stalled receiver holds req_ready low only while a result is pending.
//   Reset clears the window, the byte counter, the match flag and the
//   result valid flag, and sets the pattern length to 1.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wbps_pkg::BYTE_BITS-1:0]        req_data_byte,
   input  logic                                  req_last_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   output logic [wbps_pkg::MATCH_OFFSET_BITS-1:0] rsp_match_offset,
   input  logic                                  csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wbps_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import wbps_pkg::*;

   // Configuration
   logic [CSR_DATA_BITS-1:0]     pattern_low_ff;
   logic [CSR_DATA_BITS-1:0]     pattern_high_ff;
   logic [LEN_BITS-1:0]          pattern_len_ff;
   pattern_type                  pattern;
   logic [LEN_BITS-1:0]          eff_len;

   // Region state
   logic [OFFSET_BITS-1:0]       bytes_seen_ff;
   logic [OFFSET_BITS-1:0]       bytes_seen_in;
   logic                         match_reported_ff;
   logic                         match_reported_in;

   // Result register
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_found_ff;
   logic [MATCH_OFFSET_BITS-1:0] rsp_offset_ff;

   logic                         accept;
   logic                         matched;
   logic                         rsp_load;
   logic                         rsp_load_found;
   logic [OFFSET_BITS-1:0]       count_next;
   logic [OFFSET_BITS-1:0]       offset_full;
   cell_ctrl_type                cell_ctrl;
   byte_type                     win_byte [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] hits;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= LEN_BITS'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_PATTERN_LOW:  pattern_low_ff  <= csr_write_data;
            REG_PATTERN_HIGH: pattern_high_ff <= csr_write_data;
            REG_PATTERN_LEN:  pattern_len_ff  <= csr_write_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Pattern bytes in order and the length in effect
   always_comb begin
      pattern = pattern_type'({pattern_high_ff, pattern_low_ff});
      if (pattern_len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (pattern_len_ff > LEN_BITS'(LEN_CAP)) begin
         eff_len = LEN_BITS'(LEN_CAP);
      end else begin
         eff_len = pattern_len_ff;
      end
   end

   // Take a byte whenever the result register is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Row of window cells, entry 0 the newest
   for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      byte_type cell_in;
      if (j == 0) begin : g_head
         assign cell_in = req_data_byte;
      end else begin : g_link
         assign cell_in = win_byte[j-1];
      end
      wbps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .cell_index (CELL_INDEX_BITS'(j)),
         .eff_len    (eff_len),
         .pattern    (pattern),
         .byte_in    (cell_in),
         .byte_out   (win_byte[j]),
         .hit        (hits[j])
      );
   end

   // Decide what this beat does to the region and the result register
   always_comb begin
      count_next = (bytes_seen_ff == '1) ? bytes_seen_ff : bytes_seen_ff + OFFSET_BITS'(1);
      offset_full = count_next - OFFSET_BITS'(eff_len);
      matched = (count_next >= OFFSET_BITS'(eff_len)) && (&hits);

      cell_ctrl.shift   = accept && !match_reported_ff;
      cell_ctrl.clear   = accept && req_last_byte;
      rsp_load          = accept && !match_reported_ff && (matched || req_last_byte);
      rsp_load_found    = matched;

      bytes_seen_in     = bytes_seen_ff;
      match_reported_in = match_reported_ff;
      if (accept) begin
         if (req_last_byte) begin
            bytes_seen_in     = '0;
            match_reported_in = 1'b0;
         end else if (!match_reported_ff) begin
            bytes_seen_in     = count_next;
            match_reported_in = matched;
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // Advance region state
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff     <= '0;
         match_reported_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         bytes_seen_ff     <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff  <= rsp_load_found;
         rsp_offset_ff <= rsp_load_found ? MATCH_OFFSET_BITS'(offset_full) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // A not-found result always carries offset zero
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("not-found result with nonzero offset");

   // A region end leaves the counter and match flag cleared
   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> bytes_seen_ff == '0 && !match_reported_ff)
      else $error("region state not cleared after last byte");

   // No result once a match has been reported in the region
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      accept && match_reported_ff |-> !rsp_load)
      else $error("second result in one region");

   // A pending result is never overwritten while the receiver stalls
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !rsp_load)
      else $error("result register overwritten while stalled");

endmodule
